// ----- rtl/core/tfsm_pkg.sv -----
// Shared types, constants and codes for the transmit frame slot manager.
`timescale 1ns / 1ps

package tfsm_pkg;

    localparam int SLOTS  = 2;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int LEN_W      = 16;
    localparam int REG_IDX_W  = 1;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [SLOTS-1:0]     t_mask;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    // item kinds
    localparam logic [1:0] KIND_SUBMIT  = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_SERVICE = 2'd2;
    localparam logic [1:0] KIND_STOP    = 2'd3;

    // submit status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_NO_SLOT  = 2'd3;

    // configuration register indexes
    localparam t_reg_idx REG_BUFFER_BYTES    = REG_IDX_W'(0);
    localparam t_reg_idx REG_MIN_FRAME_BYTES = REG_IDX_W'(1);

    localparam t_len BUFFER_BYTES_RST    = LEN_W'(2048);
    localparam t_len MIN_FRAME_BYTES_RST = LEN_W'(60);

    // result of a round-robin search
    typedef struct packed {
        logic  found;
        t_slot idx;
    } t_pick;

endpackage

// ----- rtl/core/tfsm_rr_pick.sv -----
// Round-robin first-set search over the slot mask, starting at a given slot.
`timescale 1ns / 1ps

module tfsm_rr_pick (
    input  tfsm_pkg::t_mask i_mask,
    input  tfsm_pkg::t_slot i_start,
    output tfsm_pkg::t_pick o_pick
);
    import tfsm_pkg::*;

    always_comb begin
        logic [SLOT_W:0] v_sum;
        o_pick = '0;
        // walk from the farthest candidate back so the nearest one wins
        for (int c = SLOTS - 1; c >= 0; c--) begin
            v_sum = {1'b0, i_start} + (SLOT_W + 1)'(c);
            if (v_sum >= (SLOT_W + 1)'(SLOTS)) begin
                v_sum = v_sum - (SLOT_W + 1)'(SLOTS);
            end
            if (i_mask[v_sum[SLOT_W-1:0]]) begin
                o_pick.found = 1'b1;
                o_pick.idx   = v_sum[SLOT_W-1:0];
            end
        end
    end

endmodule

// ----- rtl/core/tx_frame_slot_manager_top.sv -----
// Top level of the transmit frame slot manager: slot bookkeeping and result register.
`timescale 1ns / 1ps
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle; the slot state updates at the accept edge, so
// the next item sees it at once. A waiting result stalls input only when the
// output register is full and not being taken.
// Reset (synchronous, active low): all slots free and idle, pointers at slot 0,
// registers back to 2048 / 60 bytes, output register empty.

module tx_frame_slot_manager_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  tfsm_pkg::t_reg_idx   i_cfg_index,
    input  logic [15:0]          i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_kind,
    input  logic [15:0]          i_frame_length,

    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [2:0]           o_write_slot,
    output logic                 o_padded,
    output logic                 o_start_valid,
    output logic [2:0]           o_start_slot,
    output logic [15:0]          o_start_length,
    output logic                 o_completed,
    output logic [2:0]           o_completed_slot,
    output logic [3:0]           o_free_slots,
    output logic                 o_dma_stop
);
    import tfsm_pkg::*;

    // configuration
    t_len  r_buffer_bytes;
    t_len  r_min_frame;

    // slot state
    t_mask r_queued;
    t_len  r_len [SLOTS];
    t_slot r_active;
    t_slot r_next_sub;
    logic  r_busy;
    logic  r_done;

    t_mask n_queued;
    t_len  n_len [SLOTS];
    t_slot n_active;
    t_slot n_next_sub;
    logic  n_busy;
    logic  n_done;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_status;
    t_slot       r_write_slot;
    logic        r_padded;
    logic        r_start_valid;
    t_slot       r_start_slot;
    t_len        r_start_length;
    logic        r_completed;
    t_slot       r_completed_slot;
    logic [CNT_W-1:0] r_free_slots;
    logic        r_dma_stop;

    logic [1:0]  n_status;
    t_slot       n_write_slot;
    logic        n_padded;
    logic        n_start_valid;
    t_slot       n_start_slot;
    t_len        n_start_length;
    logic        n_completed;
    t_slot       n_completed_slot;
    logic [CNT_W-1:0] n_free_slots;
    logic        n_dma_stop;

    t_mask n_queued_pre;
    logic  n_busy_pre;
    logic  n_try_start;
    t_mask free_mask;
    t_pick free_pick;
    t_pick queue_pick;
    t_len  padded_len;
    logic  in_accept;

    assign in_accept = i_valid && o_ready;
    assign o_ready   = !r_out_valid || i_ready;

    assign free_mask  = ~(r_queued | (r_busy ? (t_mask'(1) << r_active) : '0));
    assign padded_len = (i_frame_length < r_min_frame) ? r_min_frame : i_frame_length;

    tfsm_rr_pick u_free_pick (
        .i_mask  (free_mask),
        .i_start (r_next_sub),
        .o_pick  (free_pick)
    );

    tfsm_rr_pick u_queue_pick (
        .i_mask  (n_queued_pre),
        .i_start (r_active),
        .o_pick  (queue_pick)
    );

    // kind-specific update, before any start
    always_comb begin
        n_queued_pre     = r_queued;
        n_len            = r_len;
        n_busy_pre       = r_busy;
        n_done           = r_done;
        n_next_sub       = r_next_sub;
        n_status         = ST_OK;
        n_write_slot     = '0;
        n_padded         = 1'b0;
        n_completed      = 1'b0;
        n_completed_slot = '0;
        n_dma_stop       = 1'b0;
        n_try_start      = 1'b0;

        unique case (i_kind)
            KIND_SUBMIT: begin
                priority if (i_frame_length == '0) begin
                    n_status = ST_ZERO_LEN;
                end else if (i_frame_length > r_buffer_bytes) begin
                    n_status = ST_TOO_LONG;
                end else if (!free_pick.found) begin
                    n_status = ST_NO_SLOT;
                end else if (padded_len > r_buffer_bytes) begin
                    // min frame set above the buffer size
                    n_status = ST_TOO_LONG;
                end else begin
                    n_write_slot                 = free_pick.idx;
                    n_padded                     = padded_len > i_frame_length;
                    n_len[free_pick.idx]         = padded_len;
                    n_queued_pre[free_pick.idx]  = 1'b1;
                    n_next_sub = (free_pick.idx == t_slot'(SLOTS - 1)) ? '0
                                                                       : free_pick.idx + 1'b1;
                    n_try_start = 1'b1;
                end
            end
            KIND_DONE: begin
                if (r_busy) begin
                    n_done = 1'b1;
                end
            end
            KIND_SERVICE: begin
                if (!r_busy) begin
                    n_try_start = 1'b1;
                end else if (r_done) begin
                    n_completed      = 1'b1;
                    n_completed_slot = r_active;
                    n_busy_pre       = 1'b0;
                    n_done           = 1'b0;
                    n_len[r_active]  = '0;
                    n_try_start      = 1'b1;
                end
            end
            KIND_STOP: begin
                n_dma_stop   = 1'b1;
                n_busy_pre   = 1'b0;
                n_done       = 1'b0;
                n_queued_pre = '0;
                for (int s = 0; s < SLOTS; s++) begin
                    n_len[s] = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // start the next queued slot when the engine is idle, then count free slots
    always_comb begin
        t_mask v_occ;
        n_queued       = n_queued_pre;
        n_active       = r_active;
        n_busy         = n_busy_pre;
        n_start_valid  = 1'b0;
        n_start_slot   = '0;
        n_start_length = '0;

        if (n_try_start && !n_busy_pre && queue_pick.found) begin
            n_queued[queue_pick.idx] = 1'b0;
            n_active       = queue_pick.idx;
            n_busy         = 1'b1;
            n_start_valid  = 1'b1;
            n_start_slot   = queue_pick.idx;
            n_start_length = n_len[queue_pick.idx];
        end

        v_occ        = n_queued | (n_busy ? (t_mask'(1) << n_active) : '0);
        n_free_slots = '0;
        for (int s = 0; s < SLOTS; s++) begin
            n_free_slots = n_free_slots + CNT_W'(!v_occ[s]);
        end
    end

    // done_pending also drops when a new transfer starts
    logic n_done_final;
    assign n_done_final = n_start_valid ? 1'b0 : n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes <= BUFFER_BYTES_RST;
            r_min_frame    <= MIN_FRAME_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BUFFER_BYTES:    r_buffer_bytes <= i_cfg_data;
                REG_MIN_FRAME_BYTES: r_min_frame    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued   <= '0;
            r_active   <= '0;
            r_next_sub <= '0;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_len[s] <= '0;
            end
        end else if (in_accept) begin
            r_queued   <= n_queued;
            r_active   <= n_active;
            r_next_sub <= n_next_sub;
            r_busy     <= n_busy;
            r_done     <= n_done_final;
            r_len      <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status         <= n_status;
            r_write_slot     <= n_write_slot;
            r_padded         <= n_padded;
            r_start_valid    <= n_start_valid;
            r_start_slot     <= n_start_slot;
            r_start_length   <= n_start_length;
            r_completed      <= n_completed;
            r_completed_slot <= n_completed_slot;
            r_free_slots     <= n_free_slots;
            r_dma_stop       <= n_dma_stop;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_write_slot     = 3'(r_write_slot);
    assign o_padded         = r_padded;
    assign o_start_valid    = r_start_valid;
    assign o_start_slot     = 3'(r_start_slot);
    assign o_start_length   = r_start_length;
    assign o_completed      = r_completed;
    assign o_completed_slot = 3'(r_completed_slot);
    assign o_free_slots     = 4'(r_free_slots);
    assign o_dma_stop       = r_dma_stop;

endmodule
